// ===== design/clip_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clip_pkg
// Types and codes shared by the C integer literal parser modules.
// ----------------------------------------------------------------------------
package clip_pkg;

  localparam int unsigned MAG_BITS = 64;

  typedef struct packed {
    logic [7:0] character;
    logic       has_char;
    logic       last;
  } clip_in_t;

  typedef struct packed {
    logic [MAG_BITS-1:0] magnitude;
    logic                is_negative;
    logic [2:0]          error_code;
  } clip_out_t;

  typedef enum logic [4:0] {
    PH_START  = 5'b00001,
    PH_SIGN   = 5'b00010,
    PH_ZERO   = 5'b00100,
    PH_DIGITS = 5'b01000,
    PH_SUFFIX = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_HEX = 2'd1,
    RX_BIN = 2'd2
  } radix_t;

  typedef enum logic [2:0] {
    ER_NONE   = 3'd0,
    ER_EMPTY  = 3'd1,
    ER_SIGN   = 3'd2,
    ER_FLOAT  = 3'd3,
    ER_NODIG  = 3'd4,
    ER_SUFFIX = 3'd5
  } err_t;

  typedef struct packed {
    phase_t phase;
    radix_t radix;
    logic   minus_seen;
    logic   digit_seen;
    err_t   sticky_error;
  } clip_state_t;

  localparam clip_state_t STATE_RESET = '{
    phase:        PH_START,
    radix:        RX_DEC,
    minus_seen:   1'b0,
    digit_seen:   1'b0,
    sticky_error: ER_NONE
  };

endpackage
`default_nettype wire

// ===== design/clip_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clip_step
// One character of literal text: next parser state, accumulator and result.
// ----------------------------------------------------------------------------
module clip_step
  import clip_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 64
) (
  input  clip_state_t           st,
  input  logic [VALUE_BITS-1:0] acc,
  input  clip_in_t              item,
  output clip_state_t           st_next,
  output logic [VALUE_BITS-1:0] acc_next,
  output clip_out_t             result
);

  logic [7:0]            c;
  logic                  dig_ok;
  logic [3:0]            dig;
  logic [VALUE_BITS-1:0] acc_shift;
  logic [VALUE_BITS-1:0] acc_dig;
  logic                  is_sfx;
  logic                  is_flt;
  clip_state_t           st_dp;
  logic [VALUE_BITS-1:0] acc_dp;
  clip_state_t           st_c;
  logic [VALUE_BITS-1:0] acc_c;
  err_t                  err;

  assign c = item.character;

  always_comb begin
    dig_ok = 1'b0;
    dig    = 4'd0;
    if (st.radix == RX_BIN) begin
      dig_ok = (c == "0") || (c == "1");
      dig    = c[3:0];
    end else if (c inside {["0":"9"]}) begin
      dig_ok = 1'b1;
      dig    = c[3:0];
    end else if (st.radix == RX_HEX && (c inside {["a":"f"], ["A":"F"]})) begin
      dig_ok = 1'b1;
      dig    = c[3:0] + 4'd9;
    end
  end

  assign is_sfx = c inside {"u", "U", "l", "L", "w", "W"};
  assign is_flt = c inside {".", "e", "E", "p", "P"};

  always_comb begin
    case (st.radix)
      RX_HEX:  acc_shift = acc << 4;
      RX_BIN:  acc_shift = acc << 1;
      default: acc_shift = (acc << 3) + (acc << 1);
    endcase
  end

  assign acc_dig = acc_shift + VALUE_BITS'(dig);

  // digit-phase handling, phase field left for the caller
  always_comb begin
    st_dp  = st;
    acc_dp = acc;
    if (c != "'") begin
      if (dig_ok) begin
        acc_dp           = acc_dig;
        st_dp.digit_seen = 1'b1;
      end else if (is_flt) begin
        st_dp.sticky_error = ER_FLOAT;
      end else if (!st.digit_seen) begin
        st_dp.sticky_error = ER_NODIG;
      end else if (is_sfx) begin
        st_dp.phase = PH_SUFFIX;
      end else begin
        st_dp.sticky_error = ER_SUFFIX;
      end
    end
  end

  always_comb begin
    st_c  = st;
    acc_c = acc;
    if (item.has_char && st.sticky_error == ER_NONE) begin
      case (st.phase)
        PH_START, PH_SIGN: begin
          if (st.phase == PH_START && (c == "+" || c == "-")) begin
            st_c.minus_seen = (c == "-");
            st_c.phase      = PH_SIGN;
          end else if (c == "0") begin
            st_c.phase      = PH_ZERO;
            st_c.digit_seen = 1'b1;
            acc_c           = '0;
          end else begin
            st_c = st_dp;
            if (st_dp.phase != PH_SUFFIX) st_c.phase = PH_DIGITS;
            acc_c = acc_dp;
          end
        end
        PH_ZERO: begin
          if (c == "x" || c == "X") begin
            st_c.phase      = PH_DIGITS;
            st_c.radix      = RX_HEX;
            st_c.digit_seen = 1'b0;
          end else if (c == "b" || c == "B") begin
            st_c.phase      = PH_DIGITS;
            st_c.radix      = RX_BIN;
            st_c.digit_seen = 1'b0;
          end else begin
            st_c = st_dp;
            if (st_dp.phase != PH_SUFFIX) st_c.phase = PH_DIGITS;
            acc_c = acc_dp;
          end
        end
        PH_DIGITS: begin
          st_c  = st_dp;
          acc_c = acc_dp;
        end
        default: begin
          if (!is_sfx) st_c.sticky_error = ER_SUFFIX;
        end
      endcase
    end
  end

  always_comb begin
    err = st_c.sticky_error;
    if (err == ER_NONE) begin
      if (st_c.phase == PH_START) begin
        err = ER_EMPTY;
      end else if (st_c.phase == PH_SIGN) begin
        err = ER_SIGN;
      end else if (st_c.phase == PH_DIGITS && !st_c.digit_seen) begin
        err = ER_NODIG;
      end
    end
  end

  always_comb begin
    result.error_code  = err;
    result.magnitude   = '0;
    result.is_negative = 1'b0;
    if (err == ER_NONE) begin
      result.magnitude   = MAG_BITS'(acc_c);
      result.is_negative = st_c.minus_seen && (acc_c != '0);
    end
  end

  always_comb begin
    if (item.last) begin
      st_next  = STATE_RESET;
      acc_next = '0;
    end else begin
      st_next  = st_c;
      acc_next = acc_c;
    end
  end

endmodule
`default_nettype wire

// ===== design/c_integer_literal_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// c_integer_literal_parser
// Parses a C integer literal streamed one character per item.
// ----------------------------------------------------------------------------
// Takes one character per cycle, with has_char and last flags. Sign, 0x/0b
// prefix, apostrophe separators and u/l/w suffixes are handled; the value
// wraps modulo 2^VALUE_BITS. The item marked last yields one result: magnitude,
// sign and the first error found. The item passes the input register, then the
// result register, before the result is valid. One item is accepted every cycle
// through the combinational accumulate step (shift plus add of the VALUE_BITS-bit
// value); the input stalls only while a last item waits behind a result that
// has not been taken yet.
module c_integer_literal_parser
  import clip_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  clip_in_t  item,
  output logic      result_valid,
  input  logic      result_ready,
  output clip_out_t result
);

  logic                  iv;
  clip_in_t              item_q;
  logic                  advance;
  clip_state_t           st;
  clip_state_t           st_next;
  logic [VALUE_BITS-1:0] acc;
  logic [VALUE_BITS-1:0] acc_next;
  clip_out_t             res_next;

  assign advance    = iv && (!item_q.last || !result_valid || result_ready);
  assign item_ready = !iv || advance;

  clip_step #(
    .VALUE_BITS(VALUE_BITS)
  ) u_step (
    .st       (st),
    .acc      (acc),
    .item     (item_q),
    .st_next  (st_next),
    .acc_next (acc_next),
    .result   (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (item_ready) begin
      iv <= item_valid;
    end
    if (item_ready && item_valid) begin
      item_q <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= STATE_RESET;
      acc <= '0;
    end else if (advance) begin
      st  <= st_next;
      acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && item_q.last) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (advance && item_q.last) begin
      result <= res_next;
    end
  end

endmodule
`default_nettype wire
